[rtl/indexed_insert_delete_array_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the indexed insert/delete array
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define IIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed array check failed");
// Next-cycle implication, disabled during reset.
`define IIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed array check failed");
`else
`define IIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/iida_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iida_pkg
// Types, codes and sizes shared by the indexed insert/delete array.
// ---------------------------------------------------------------------------
package iida_pkg;

  localparam int CAPACITY = 128;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 3;
  localparam int FILL_W   = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Width wide enough for a count, a position and a position plus one.
  localparam int CMP_W    = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } fsm_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;
    logic signed [WORD_W-1:0] read_word;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [CMP_W-1:0]  slot;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

[rtl/iida_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iida_cell
// One storage slot of the chain: holds, shifts or loads its word.
// ---------------------------------------------------------------------------
module iida_cell import iida_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word_o,
  output logic [WORD_W-1:0] rd_o
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [CMP_W-1:0]  my_idx;

  assign my_idx = CMP_W'(idx);

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      OP_INSERT: begin
        if (my_idx > ctl.slot) begin
          word_nxt = left_word;
        end else if (my_idx == ctl.slot) begin
          word_nxt = ctl.word;
        end
      end
      OP_DELETE: begin
        if (my_idx >= ctl.slot) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  assign rd_o   = (ctl.op == OP_READ && my_idx == ctl.slot) ? word_r : '0;

endmodule

[rtl/iida_rdgrp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iida_rdgrp
// First level of the read tree: ORs the masked words of a group of cells.
// ---------------------------------------------------------------------------
module iida_rdgrp import iida_pkg::*; (
  input  logic              clk,
  input  logic [WORD_W-1:0] rd_in [GRP_SIZE],
  output logic [WORD_W-1:0] rd_o
);

  logic [WORD_W-1:0] grp_r;
  logic [WORD_W-1:0] grp_nxt;

  // At most one cell drives a nonzero word, so OR acts as a select.
  always_comb begin
    grp_nxt = '0;
    for (int i = 0; i < GRP_SIZE; i++) begin
      grp_nxt = grp_nxt | rd_in[i];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign rd_o = grp_r;

endmodule

[rtl/indexed_insert_delete_array_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Ordered store of signed words with insert, delete and read at an index.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                          Moves
//   input     in_valid, in_stall, in_item    command, position, data word
//   output    out_valid, out_stall, out_item status, fill count, read word
//
// Each item passes through the accept, execute and read-tree reduction steps. The
// next item is accepted in the cycle after the result is loaded into the
// output register, so the block takes no new item before the last one is
// through; the registered two-level read tree needs the reduction step.
// Reset clears the fill count, the control state and the output valid; the
// cell words are not reset, and only entries below the count are ever read.
// A stalled output holds its item while the next item is accepted and
// executed; that item then waits in the reduction step until the output frees.
//
`include "indexed_insert_delete_array_top_assert.svh"

module indexed_insert_delete_array_top import iida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  fsm_t              state_r;
  fsm_t              state_nxt;
  in_item_t          cmd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_item_r;
  logic              in_fire;
  logic              out_load;

  cell_ctl_t         ctl;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  pos_p1;
  logic [CMP_W-1:0]  cnt_w;
  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] cell_rd   [NGRP*GRP_SIZE];
  logic [WORD_W-1:0] grp_rd    [NGRP];
  logic [WORD_W-1:0] rd_word;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // Command decode: status for the held command and the broadcast to cells.
  // The cells only move when the command is accepted as valid.
  assign pos_w  = CMP_W'(cmd_r.position);
  assign pos_p1 = pos_w + CMP_W'(1);
  assign cnt_w  = CMP_W'(cnt_r);

  always_comb begin
    status_nxt = ST_OK;
    cnt_nxt    = cnt_r;
    ctl.op     = OP_HOLD;
    ctl.slot   = pos_w;
    ctl.word   = cmd_r.data_word;
    case (cmd_r.cmd)
      CMD_INS_BEFORE, CMD_INS_AFTER: begin
        ctl.slot = (cmd_r.cmd == CMD_INS_BEFORE) ? pos_w : pos_p1;
        if (cnt_w >= CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (ctl.slot > cnt_w) begin
          status_nxt = ST_BADIDX;
        end else begin
          ctl.op  = OP_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_DEL_BEFORE: begin
        ctl.slot = pos_w - CMP_W'(1);
        if (pos_w >= CMP_W'(1) && pos_w < cnt_w) begin
          ctl.op  = OP_DELETE;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_BADIDX;
        end
      end
      CMD_DEL_AFTER: begin
        ctl.slot = pos_p1;
        if (pos_p1 < cnt_w) begin
          ctl.op  = OP_DELETE;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_BADIDX;
        end
      end
      CMD_READ: begin
        if (pos_w < cnt_w) begin
          ctl.op = OP_READ;
        end else begin
          status_nxt = ST_BADIDX;
        end
      end
      default: status_nxt = ST_BADIDX;
    endcase
    // Only the execute cycle may change the cells. A read keeps its select
    // while the item waits in the reduction step, so the group registers
    // keep the word until the output register takes it.
    if (!(state_r == S_EXEC || (state_r == S_REDUCE && ctl.op == OP_READ))) begin
      ctl.op = OP_HOLD;
    end
  end

  // The chain of cells. Inserts pull from the left neighbor, deletes from
  // the right one; the ends see zero, which no valid command ever selects.
  for (genvar i = 0; i < NGRP*GRP_SIZE; i++) begin : g_cell
    if (i < CAPACITY) begin : g_used
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_word[i+1];
      end
      iida_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (IDX_W'(i)),
        .left_word (left_w),
        .right_word(right_w),
        .word_o    (cell_word[i]),
        .rd_o      (cell_rd[i])
      );
    end else begin : g_pad
      assign cell_rd[i] = '0;
    end
  end

  // Read tree, first level: one registered OR per group of cells.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [WORD_W-1:0] grp_in [GRP_SIZE];
    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_tap
      assign grp_in[j] = cell_rd[g*GRP_SIZE + j];
    end
    iida_rdgrp u_grp (
      .clk  (clk),
      .rd_in(grp_in),
      .rd_o (grp_rd[g])
    );
  end

  // Second level: OR of the group registers, loaded into the output register.
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_rd[g];
    end
  end

  assign out_load = (state_r == S_REDUCE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_REDUCE;
      S_REDUCE: begin
        if (out_load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_item;
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_item_r.status     <= status_r;
      out_item_r.fill_count <= FILL_W'(cnt_r);
      out_item_r.read_word  <= rd_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks on the block's own sequencing and bookkeeping.
  `IIDA_ASSERT_IMPLY(a_cnt_cap, clk, rst_n, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `IIDA_ASSERT_NEXT(a_fire_exec, clk, rst_n, in_fire, state_r == S_EXEC)
  `IIDA_ASSERT_IMPLY(a_full_cnt, clk, rst_n, state_r == S_EXEC && status_nxt == ST_FULL, cnt_r == CNT_W'(CAPACITY))
  `IIDA_ASSERT_NEXT(a_reject_hold, clk, rst_n, state_r == S_EXEC && status_nxt != ST_OK, $stable(cnt_r))

endmodule
